// ----- rtl/ihds_pkg.sv -----
// shared types, constants and helper functions of the image header dimension sniffer
package ihds_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int LEAD_LEN     = 24;
    localparam int WIN_LEN      = 12;
    localparam int FIRST_TARGET = WIN_LEN + 1;
    localparam int MIN_LAST_POS = LEAD_LEN - 1;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] fmt_t;

    localparam fmt_t FMT_NONE = 2'd0;
    localparam fmt_t FMT_JPEG = 2'd1;
    localparam fmt_t FMT_GIF  = 2'd2;
    localparam fmt_t FMT_PNG  = 2'd3;

    localparam byte_t MARK_PREFIX = 8'hFF;
    localparam byte_t MARK_SOI    = 8'hD8;
    localparam byte_t MARK_APP0   = 8'hE0;
    localparam byte_t MARK_SOF0   = 8'hC0;
    localparam byte_t MARK_SOF1   = 8'hC1;
    localparam byte_t MARK_SOF2   = 8'hC2;
    localparam byte_t MARK_SOF3   = 8'hC3;
    localparam byte_t MARK_SOF9   = 8'hC9;
    localparam byte_t MARK_SOF10  = 8'hCA;
    localparam byte_t MARK_SOF11  = 8'hCB;
    localparam byte_t PNG_HIGH    = 8'h89;
    localparam byte_t CHR_SUB     = 8'h1A;
    localparam byte_t CHR_CR      = 8'h0D;
    localparam byte_t CHR_LF      = 8'h0A;

    typedef struct packed {
        logic                   found;
        fmt_t                   format;
        logic [31:0]            width;
        logic [31:0]            height;
    } result_t;

    typedef struct packed {
        logic                   active;
        byte_t [WIN_LEN-1:0]    bytes;
    } window_t;

    function automatic logic is_sof(input byte_t m);
        return m inside {MARK_SOF0, MARK_SOF1, MARK_SOF2, MARK_SOF3,
                         MARK_SOF9, MARK_SOF10, MARK_SOF11};
    endfunction

    function automatic logic is_jfif(input byte_t [LEAD_LEN-1:0] b);
        return b[0] == MARK_PREFIX && b[1] == MARK_SOI && b[2] == MARK_PREFIX &&
               b[3] == MARK_APP0 && b[6] == "J" && b[7] == "F" &&
               b[8] == "I" && b[9] == "F";
    endfunction

endpackage

// ----- rtl/ihds_if.sv -----
// request channels of the sniffer: file bytes in, header results out
interface ihds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface ihds_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  format;
    logic [31:0] width;
    logic [31:0] height;

    modport source (output valid, output found, output format, output width,
                    output height, input ready);
    modport sink   (input valid, input found, input format, input width,
                    input height, output ready);
endinterface

// ----- rtl/ihds_walker.sv -----
// jfif segment walker: 12-byte shift line, window capture and next segment target
module ihds_walker #(
    parameter int POS_BITS = ihds_pkg::POS_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        step,
    input  logic                                        clear,
    input  ihds_pkg::byte_t                             data,
    input  logic [POS_BITS-1:0]                         pos,
    input  logic                                        jfif,
    output ihds_pkg::window_t                           view
);
    import ihds_pkg::*;

    localparam int SUM_BITS = ((POS_BITS > 17) ? POS_BITS : 17) + 1;

    byte_t [WIN_LEN-1:0]    shift_reg;
    byte_t [WIN_LEN-1:0]    shift_next;
    byte_t [WIN_LEN-1:0]    win_reg;
    logic [POS_BITS-1:0]    target_reg;
    logic [POS_BITS-1:0]    target_next;
    logic                   reach_reg;
    logic                   reach_next;
    logic                   active_reg;
    logic                   active_next;
    logic                   finished_reg;
    logic                   finished_next;
    logic                   hit;
    logic                   reject;
    logic                   capture;
    logic                   stop;
    logic [SUM_BITS-1:0]    sum;

    assign shift_next = {data, shift_reg[WIN_LEN-1:1]};
    assign hit        = step && !finished_reg && reach_reg && pos == target_reg;
    // first window of a file that is not jfif ends the walk without capture
    assign reject     = hit && pos == POS_BITS'(FIRST_TARGET) && !jfif;
    assign capture    = hit && !reject;
    assign stop       = shift_next[0] != MARK_PREFIX || is_sof(shift_next[1]);
    assign sum        = SUM_BITS'(target_reg) + SUM_BITS'(2)
                      + SUM_BITS'({shift_next[2], shift_next[3]});

    always_comb
    begin
        target_next   = target_reg;
        reach_next    = reach_reg;
        active_next   = active_reg;
        finished_next = finished_reg;
        if (reject)
        begin
            finished_next = 1'b1;
        end
        else if (capture)
        begin
            active_next = 1'b1;
            if (stop)
            begin
                finished_next = 1'b1;
            end
            else
            begin
                target_next = sum[POS_BITS-1:0];
                reach_next  = sum[SUM_BITS-1:POS_BITS] == '0;
            end
        end
        if (clear)
        begin
            target_next   = POS_BITS'(FIRST_TARGET);
            reach_next    = 1'b1;
            active_next   = 1'b0;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= POS_BITS'(FIRST_TARGET);
            reach_reg    <= 1'b1;
            active_reg   <= 1'b0;
            finished_reg <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            reach_reg    <= reach_next;
            active_reg   <= active_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            shift_reg <= shift_next;
        end
        if (capture)
        begin
            win_reg <= shift_next;
        end
    end

    assign view.active = capture ? 1'b1 : active_reg;
    assign view.bytes  = capture ? shift_next : win_reg;

endmodule

// ----- rtl/ihds_classifier.sv -----
// header decode: format test in priority order and dimension extraction
module ihds_classifier (
    input  ihds_pkg::byte_t [ihds_pkg::LEAD_LEN-1:0]    lead,
    input  ihds_pkg::window_t                           win,
    input  logic                                        long_enough,
    output ihds_pkg::result_t                           res
);
    import ihds_pkg::*;

    byte_t [LEAD_LEN-1:0] hdr;

    always_comb
    begin
        hdr = lead;
        if (win.active)
        begin
            hdr[WIN_LEN+1:2] = win.bytes;
        end
    end

    always_comb
    begin
        res = '0;
        res.format = FMT_NONE;
        if (long_enough)
        begin
            if (hdr[0] == MARK_PREFIX && hdr[1] == MARK_SOI && hdr[2] == MARK_PREFIX)
            begin
                res.found  = 1'b1;
                res.format = FMT_JPEG;
                res.height = {16'd0, hdr[7], hdr[8]};
                res.width  = {16'd0, hdr[9], hdr[10]};
            end
            else if (hdr[0] == "G" && hdr[1] == "I" && hdr[2] == "F")
            begin
                res.found  = 1'b1;
                res.format = FMT_GIF;
                res.width  = {16'd0, hdr[7], hdr[6]};
                res.height = {16'd0, hdr[9], hdr[8]};
            end
            else if (hdr[0] == PNG_HIGH && hdr[1] == "P" && hdr[2] == "N" &&
                     hdr[3] == "G" && hdr[4] == CHR_CR && hdr[5] == CHR_LF &&
                     hdr[6] == CHR_SUB && hdr[7] == CHR_LF && hdr[12] == "I" &&
                     hdr[13] == "H" && hdr[14] == "D" && hdr[15] == "R")
            begin
                res.found  = 1'b1;
                res.format = FMT_PNG;
                res.width  = {hdr[16], hdr[17], hdr[18], hdr[19]};
                res.height = {hdr[20], hdr[21], hdr[22], hdr[23]};
            end
        end
    end

endmodule

// ----- rtl/image_header_dimension_sniffer.sv -----
// top level of the image header dimension sniffer
// takes one file byte per request, the final byte flagged by end_of_file, and
// answers with a single result request on that final byte: png (signature and
// ihdr), gif or jpeg with width and height, or not found for anything else and
// for files shorter than 24 bytes. jfif files are followed segment by segment
// through their length fields until a start-of-frame marker, a window that does
// not open with ff, or a window that would run past the end of the file; the
// dimensions come from the last complete 12-byte window. a byte is taken every
// cycle, except that the input side stalls only while a result is held and the
// next final byte is waiting behind it. one input register, one level of
// compare/capture logic plus the segment offset adder, and the result register
// lie between the final byte and its result. after each result the stream
// state returns to its start values, so files may follow back to back.
module image_header_dimension_sniffer #(
    parameter int POS_BITS = ihds_pkg::POS_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    ihds_in_if.sink         stream,
    ihds_out_if.source      result
);
    import ihds_pkg::*;

    // input register
    logic                   in_vld_reg;
    byte_t                  in_byte_reg;
    logic                   in_eof_reg;

    // stream position and the first bytes of the file
    logic [POS_BITS-1:0]    pos_reg;
    byte_t [LEAD_LEN-1:0]   lead_reg;
    byte_t [LEAD_LEN-1:0]   lead_view;

    // result register
    logic                   out_vld_reg;
    result_t                res_reg;

    logic                   advance;
    logic                   step;
    logic                   pos_sat;
    logic                   finish;
    window_t                win_view;
    result_t                res_next;

    // an item moves on unless it is a final byte facing a held result
    assign advance = in_vld_reg && (!in_eof_reg || !out_vld_reg || result.ready);
    assign pos_sat = &pos_reg;
    assign step    = advance && !pos_sat;
    assign finish  = advance && in_eof_reg;

    assign stream.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_vld_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.data_byte;
            in_eof_reg  <= stream.end_of_file;
        end
    end

    // position saturates at all ones; bytes there complete no window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (finish)
        begin
            pos_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_reg + POS_BITS'(1);
        end
    end

    // leading bytes, with the byte in flight folded in for same-cycle decode
    always_comb
    begin
        for (int i = 0; i < LEAD_LEN; i++)
        begin
            lead_view[i] = (advance && pos_reg == POS_BITS'(i)) ? in_byte_reg : lead_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        lead_reg <= lead_view;
    end

    ihds_walker #(
        .POS_BITS (POS_BITS)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .clear    (finish),
        .data     (in_byte_reg),
        .pos      (pos_reg),
        .jfif     (is_jfif(lead_reg)),
        .view     (win_view)
    );

    ihds_classifier u_classifier (
        .lead        (lead_view),
        .win         (win_view),
        .long_enough (pos_reg >= POS_BITS'(MIN_LAST_POS)),
        .res         (res_next)
    );

    // result register, refilled in the cycle it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid  = out_vld_reg;
    assign result.found  = res_reg.found;
    assign result.format = res_reg.format;
    assign result.width  = res_reg.width;
    assign result.height = res_reg.height;

    // a new result only ever follows a final byte moving on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(in_vld_reg && in_eof_reg))
        else $error("result raised without a final byte");

    // not found carries no format and zero dimensions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res_reg.found |->
            res_reg.format == FMT_NONE && res_reg.width == '0 && res_reg.height == '0)
        else $error("not-found result carries data");

    // the stream restarts at position zero after a final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> pos_reg == '0)
        else $error("position not cleared after final byte");

endmodule
